FILE: rtl/qcs_pkg.sv
// qcs_pkg: shared types and constants for the quadrature count and speed core.
// Used by qcs_front, qcs_queue, qcs_back and the top level.
// No dependencies.
package qcs_pkg;

   // item kinds
   typedef enum logic [1:0] {
      KIND_EDGE0  = 2'd0,
      KIND_EDGE1  = 2'd1,
      KIND_SAMPLE = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PIN_ORDER = 2'd1;

   // microseconds per minute
   localparam logic [25:0] US_PER_MINUTE = 26'd60000000;

   typedef struct packed {
      kind_type    kind;
      logic        level;
      logic [23:0] elapsed_us;
   } req_type;

   typedef struct packed {
      logic signed [31:0] position_count;
      logic signed [31:0] speed_rpm;
   } rsp_type;

   // command handed from front to back
   typedef struct packed {
      kind_type    kind;
      logic [31:0] count;
      logic [31:0] delta;
      logic [23:0] elapsed;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

FILE: rtl/qcs_front.sv
// qcs_front: accepts items, tracks pin levels and the position count,
// and hands one command per item to the queue. Depends on qcs_pkg.
module qcs_front import qcs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req_data,
   input  logic      pin_order,
   input  qstat_type qstat,
   output push_type  push
);

   logic        a_level_ff, a_level_in;
   logic        b_level_ff, b_level_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] at_sample_ff, at_sample_in;
   logic        take;
   logic        is_a_edge;
   logic [31:0] delta;

   assign req_ready = !qstat.full;
   assign take      = req_valid && !qstat.full;
   assign delta     = count_ff - at_sample_ff;
   // pin 0 is phase A when pin_order is set
   assign is_a_edge = pin_order ? (req_data.kind == KIND_EDGE0) : (req_data.kind == KIND_EDGE1);

   // x4 decode, clear and sample bookkeeping
   always_comb begin
      a_level_in   = a_level_ff;
      b_level_in   = b_level_ff;
      count_in     = count_ff;
      at_sample_in = at_sample_ff;
      if (take) begin
         case (req_data.kind)
            KIND_EDGE0, KIND_EDGE1: begin
               if (is_a_edge) begin
                  a_level_in = req_data.level;
                  count_in   = (req_data.level != b_level_ff) ? count_ff + 32'd1
                                                              : count_ff - 32'd1;
               end else begin
                  b_level_in = req_data.level;
                  count_in   = (a_level_ff == req_data.level) ? count_ff + 32'd1
                                                              : count_ff - 32'd1;
               end
            end
            KIND_SAMPLE: begin
               at_sample_in = count_ff;
            end
            KIND_CLEAR: begin
               count_in     = '0;
               at_sample_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_level_ff   <= 1'b0;
         b_level_ff   <= 1'b0;
         count_ff     <= '0;
         at_sample_ff <= '0;
      end else begin
         a_level_ff   <= a_level_in;
         b_level_ff   <= b_level_in;
         count_ff     <= count_in;
         at_sample_ff <= at_sample_in;
      end
   end

   // command carries the count after this item
   assign push.valid       = take;
   assign push.cmd.kind    = req_data.kind;
   assign push.cmd.count   = count_in;
   assign push.cmd.delta   = delta;
   assign push.cmd.elapsed = req_data.elapsed_us;

endmodule

FILE: rtl/qcs_queue.sv
// qcs_queue: two-entry command queue between front and back.
// Depends on qcs_pkg.
module qcs_queue import qcs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  push_type  push,
   input  logic      pop,
   output cmd_type   head,
   output qstat_type qstat
);

   cmd_type    ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign qstat.full  = (fill_ff == 2'd2);
   assign qstat.empty = (fill_ff == 2'd0);
   assign do_push     = push.valid && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head        = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         ent_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule

FILE: rtl/qcs_back.sv
// qcs_back: executes queued commands, computes the sample speed with a shared
// multiplier and a serial divider, keeps the moving average with a reciprocal
// divide by the history depth, owns the result register. Depends on qcs_pkg.
module qcs_back import qcs_pkg::*; #(
   parameter int unsigned HISTORY_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [23:0] ratio,
   input  cmd_type     head,
   input  qstat_type   qstat,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   localparam int unsigned HIST_N    = HISTORY_DEPTH - 1;
   localparam int unsigned SUM_W     = 33 + $clog2(HISTORY_DEPTH);
   localparam int unsigned CNT_W     = $clog2(SUM_W + 1);
   localparam int unsigned DIV_W     = $clog2(HISTORY_DEPTH + 1);
   // average divide works a byte of quotient per step
   localparam int unsigned AVG_W     = ((SUM_W + 7) / 8) * 8;
   localparam int unsigned AVG_STEPS = AVG_W / 8;
   localparam int unsigned AX_W      = DIV_W + 8;
   localparam int unsigned R_SH      = AX_W + DIV_W;
   localparam int unsigned RC_W      = R_SH + 1;
   localparam int unsigned AP_W      = AX_W + RC_W;
   // rounded-up reciprocal of the depth, exact for every step value
   localparam logic [RC_W-1:0] RECIP = RC_W'(((64'd1 << R_SH) + 64'(HISTORY_DEPTH) - 64'd1)
                                             / 64'(HISTORY_DEPTH));
   localparam logic [AX_W-1:0] HD_X  = AX_W'(HISTORY_DEPTH);

   typedef enum logic [11:0] {
      ST_IDLE    = 12'b000000000001,
      ST_M0      = 12'b000000000010,
      ST_M1      = 12'b000000000100,
      ST_M2      = 12'b000000001000,
      ST_SUM     = 12'b000000010000,
      ST_CHK     = 12'b000000100000,
      ST_DIV     = 12'b000001000000,
      ST_SAT     = 12'b000010000000,
      ST_AVG_LD  = 12'b000100000000,
      ST_AVG_DIV = 12'b001000000000,
      ST_FIN     = 12'b010000000000,
      ST_OUT     = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   // control
   logic        rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] avg_ff, avg_in;
   logic signed [SUM_W-1:0] hist_sum_ff, hist_sum_in;
   // payload
   rsp_type     rsp_data_ff, rsp_data_in;
   logic [31:0] count_ff, count_in;
   logic        neg_ff, neg_in;
   logic [31:0] mag_ff, mag_in;
   logic [23:0] elapsed_ff, elapsed_in;
   logic [57:0] mul_ff, mul_in;
   logic [24:0] hi_ff, hi_in;
   logic [55:0] lo_ff, lo_in;
   logic [64:0] num_ff, num_in;
   logic [23:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic signed [31:0] s_ff, s_in;
   logic        aneg_ff, aneg_in;
   logic [AVG_W-1:0] amag_ff, amag_in;
   logic [DIV_W-1:0] arem_ff, arem_in;

   logic [31:0] mul_a;
   logic [25:0] mul_b;
   logic [57:0] mul_prod;
   logic [80:0] wide_sum;
   logic [25:0] trial;
   logic [AX_W-1:0] ax;
   logic [AP_W-1:0] aprod;
   logic [7:0]      aqd;
   logic [AX_W-1:0] aback;
   logic signed [SUM_W-1:0] avg_sum;
   logic signed [31:0] oldest;
   logic        out_free;
   logic        hist_push;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign mul_prod  = mul_a * mul_b;
   assign wide_sum  = {mul_ff[48:0], 32'b0} + {25'b0, lo_ff};
   assign trial     = {1'b0, rem_ff, quo_ff[31]} - {2'b0, elapsed_ff};
   // one quotient byte: remainder and next byte of the dividend
   assign ax        = {arem_ff, amag_ff[AVG_W-1 -: 8]};
   assign aprod     = AP_W'(ax) * AP_W'(RECIP);
   assign aqd       = aprod[R_SH+7:R_SH];
   assign aback     = ax - AX_W'(aqd) * HD_X;
   assign avg_sum   = hist_sum_ff + SUM_W'(s_ff);
   assign hist_push = (state_ff == ST_FIN);

   // history of instantaneous speeds, newest first
   generate
      if (HIST_N > 0) begin : g_hist
         logic signed [31:0] hist_ff [HIST_N];
         always_ff @(posedge clock) begin
            if (reset) begin
               for (int i = 0; i < HIST_N; i++) begin
                  hist_ff[i] <= '0;
               end
            end else if (hist_push) begin
               hist_ff[0] <= s_ff;
               for (int i = 1; i < HIST_N; i++) begin
                  hist_ff[i] <= hist_ff[i-1];
               end
            end
         end
         assign oldest = hist_ff[HIST_N-1];
      end else begin : g_nohist
         // no stored speeds: the new speed leaves as it enters
         assign oldest = s_ff;
      end
   endgenerate

   // sequencer
   always_comb begin
      state_in     = state_ff;
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      avg_in       = avg_ff;
      hist_sum_in  = hist_sum_ff;
      count_in     = count_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      elapsed_in   = elapsed_ff;
      mul_in       = mul_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      s_in         = s_ff;
      aneg_in      = aneg_ff;
      amag_in      = amag_ff;
      arem_in      = arem_ff;
      mul_a        = '0;
      mul_b        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               if (head.kind == KIND_SAMPLE) begin
                  pop        = 1'b1;
                  count_in   = head.count;
                  neg_in     = head.delta[31];
                  mag_in     = head.delta[31] ? (32'd0 - head.delta) : head.delta;
                  elapsed_in = head.elapsed;
                  if (head.elapsed == 24'd0) begin
                     s_in     = '0;
                     state_in = ST_AVG_LD;
                  end else begin
                     state_in = ST_M0;
                  end
               end else if (out_free) begin
                  // edge or clear: result goes straight out
                  pop          = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {head.count, avg_ff};
               end
            end
         end
         ST_M0: begin
            mul_a    = mag_ff;
            mul_b    = US_PER_MINUTE;
            mul_in   = mul_prod;
            state_in = ST_M1;
         end
         ST_M1: begin
            mul_a    = mul_ff[31:0];
            mul_b    = {2'b0, ratio};
            hi_in    = mul_ff[56:32];
            mul_in   = mul_prod;
            state_in = ST_M2;
         end
         ST_M2: begin
            mul_a    = {7'b0, hi_ff};
            mul_b    = {2'b0, ratio};
            lo_in    = mul_ff[55:0];
            mul_in   = mul_prod;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            // drop the 2^16 part of the divisor here
            num_in   = wide_sum[80:16];
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (num_ff[64:32] >= {9'b0, elapsed_ff}) begin
               // quotient needs more than 32 bits
               quo_in   = '1;
               state_in = ST_SAT;
            end else begin
               rem_in   = num_ff[55:32];
               quo_in   = num_ff[31:0];
               cnt_in   = CNT_W'(32);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // restoring divide, one quotient bit per cycle
            rem_in = trial[25] ? {rem_ff[22:0], quo_ff[31]} : trial[23:0];
            quo_in = {quo_ff[30:0], !trial[25]};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            if (neg_ff) begin
               s_in = (quo_ff > 32'h80000000) ? 32'sh80000000 : $signed(32'd0 - quo_ff);
            end else begin
               s_in = (quo_ff > 32'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(quo_ff);
            end
            state_in = ST_AVG_LD;
         end
         ST_AVG_LD: begin
            aneg_in  = avg_sum[SUM_W-1];
            amag_in  = AVG_W'(avg_sum[SUM_W-1] ? $unsigned(-avg_sum) : $unsigned(avg_sum));
            arem_in  = '0;
            cnt_in   = CNT_W'(AVG_STEPS);
            state_in = ST_AVG_DIV;
         end
         ST_AVG_DIV: begin
            // divide by the history depth, one quotient byte per cycle
            arem_in = aback[DIV_W-1:0];
            amag_in = {amag_ff[AVG_W-9:0], aqd};
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            avg_in      = aneg_ff ? $signed(32'd0 - amag_ff[31:0]) : $signed(amag_ff[31:0]);
            hist_sum_in = hist_sum_ff + SUM_W'(s_ff) - SUM_W'(oldest);
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {count_ff, avg_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         avg_ff       <= '0;
         hist_sum_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         avg_ff       <= avg_in;
         hist_sum_ff  <= hist_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      count_ff    <= count_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      elapsed_ff  <= elapsed_in;
      mul_ff      <= mul_in;
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      s_ff        <= s_in;
      aneg_ff     <= aneg_in;
      amag_ff     <= amag_in;
      arem_ff     <= arem_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/quadrature_count_and_speed_core.sv
// Quadrature x4 position counter with moving-average speed.
// req channel: one item per transfer (edge on pin 0/1, speed sample, count clear).
// rsp channel: one result per item, in order: position count and averaged speed
//   in rpm (signed Q23.8).
// csr channel: index 0 writes the Q0.24 rotations-per-count ratio, index 1 the
//   pin order; other indexes are ignored. Write only while the block is idle.
// Edge and clear items reach rsp through the queue entry and the result register
//   and sustain one item per cycle while the receiver keeps up and no sample is
//   in progress. A sample goes from transfer to result through a pop, three
//   passes through one shared multiplier, a sum, a range check, a 32-step
//   serial divider for the speed, saturation, and a byte-per-cycle reciprocal
//   divide by the history depth for the average, then the output register.
//   A saturating sample skips the serial divider and a zero elapsed time goes
//   straight to the average.
// A two-entry queue sits between the front (count logic) and the back
//   (arithmetic); the front keeps taking items until the queue fills.
// When the receiver stalls, the result stays in the output register and the
//   queue fills; req_ready drops once it is full.
// Reset (synchronous): count, levels, history, average and control registers clear;
//   no clearing pass is needed. Depends on qcs_pkg, qcs_front, qcs_queue, qcs_back.
module quadrature_count_and_speed_core import qcs_pkg::*; #(
   parameter int unsigned HISTORY_DEPTH = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [23:0]          csr_data
);

   logic [23:0] ratio_ff, ratio_in;
   logic        pin_order_ff, pin_order_in;
   push_type    push;
   qstat_type   qstat;
   cmd_type     head;
   logic        pop;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      ratio_in     = ratio_ff;
      pin_order_in = pin_order_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_RATIO:     ratio_in     = csr_data;
            CSR_PIN_ORDER: pin_order_in = csr_data[0];
            default:       ratio_in     = ratio_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff     <= '0;
         pin_order_ff <= 1'b0;
      end else begin
         ratio_ff     <= ratio_in;
         pin_order_ff <= pin_order_in;
      end
   end

   qcs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .pin_order (pin_order_ff),
      .qstat     (qstat),
      .push      (push)
   );

   qcs_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .qstat (qstat)
   );

   qcs_back #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .ratio     (ratio_ff),
      .head      (head),
      .qstat     (qstat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // back never pops an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("pop from empty command queue");

   // queue status is consistent
   a_qstat: assert property (@(posedge clock) disable iff (reset)
      !(qstat.full && qstat.empty))
      else $error("queue both full and empty");

   // no result right after reset
   a_reset_rsp: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule
